FILE: sv/sbsf_pkg.sv
// Shared types, widths and codes of the binned SAH split finder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sbsf_pkg;

    localparam int COORD_BITS = 24;
    localparam int NUM_BINS   = 16;
    localparam int BIN_W      = $clog2(NUM_BINS);
    localparam int MAX_PRIMS  = 1024;
    localparam int COST_W     = 62;
    localparam int SPAN_W     = COORD_BITS;
    localparam int AREA_W     = 2 * SPAN_W + 3;
    localparam int MUL_W      = (AREA_W + 1) / 2;
    localparam int PROD_W     = 2 * MUL_W;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] ST_SPLIT = 2'd0;
    localparam logic [1:0] ST_FLAT  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam coord_t COORD_HI = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam coord_t COORD_LO = {1'b1, {(COORD_BITS - 1){1'b0}}};

    typedef struct packed {
        coord_t lo_x;
        coord_t lo_y;
        coord_t lo_z;
        coord_t hi_x;
        coord_t hi_y;
        coord_t hi_z;
    } box_t;

    typedef struct packed {
        box_t   box;
        coord_t cx;
        coord_t cy;
        coord_t cz;
    } prim_t;

endpackage

`default_nettype wire

FILE: sv/sbsf_prim_store.sv
// Primitive store: one write port and one registered read port.
// Depends on sbsf_pkg for the primitive word layout.
`default_nettype none

module sbsf_prim_store #(
    parameter int DEPTH = sbsf_pkg::MAX_PRIMS,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire sbsf_pkg::prim_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output sbsf_pkg::prim_t      rd_data
);

    sbsf_pkg::prim_t prim_mem [DEPTH];
    sbsf_pkg::prim_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prim_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= prim_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/sbsf_bin_div.sv
// Bin index unit: restoring division, one quotient bit per cycle, with clamp.
// Depends on sbsf_pkg for coordinate and bin widths.
`default_nettype none

module sbsf_bin_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [sbsf_pkg::COORD_BITS-1:0] dividend,
    input  wire logic [sbsf_pkg::COORD_BITS-1:0] divisor,
    output logic                               done,
    output logic [sbsf_pkg::BIN_W-1:0]         quotient
);

    localparam int CW = sbsf_pkg::COORD_BITS;
    localparam int BW = sbsf_pkg::BIN_W;
    localparam int SW = $clog2(BW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic          clamp_reg;
    logic [SW-1:0] step_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] div_reg;
    logic [BW-1:0] quo_reg;
    logic [CW:0]   rem2;
    logic [CW:0]   rem_sub;
    logic          ge;
    logic [BW:0]   quo_next;

    always_comb
    begin
        rem2     = {rem_reg, 1'b0};
        ge       = rem2 >= {1'b0, div_reg};
        rem_sub  = rem2 - {1'b0, div_reg};
        quo_next = {quo_reg, ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            clamp_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                clamp_reg <= dividend >= divisor;
                step_reg  <= SW'(BW);
            end
            else if (busy_reg)
            begin
                if (clamp_reg || step_reg == SW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            div_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clamp_reg)
            begin
                quo_reg <= '1;
            end
            else
            begin
                rem_reg <= ge ? rem_sub[CW-1:0] : rem2[CW-1:0];
                quo_reg <= quo_next[BW-1:0];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: sv/sbsf_cost.sv
// Box cost unit: 2 * (xy + yz + zx) * count on one shared registered multiplier.
// Depends on sbsf_pkg for box layout, widths and the saturation limit.
`default_nettype none

module sbsf_cost #(
    parameter int CNT_W = $clog2(sbsf_pkg::MAX_PRIMS + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire sbsf_pkg::box_t             box,
    input  wire logic [CNT_W-1:0]           count,
    output logic                            done,
    output logic [sbsf_pkg::COST_W-1:0]     cost
);

    localparam int SPW   = sbsf_pkg::SPAN_W;
    localparam int MW    = sbsf_pkg::MUL_W;
    localparam int PW    = sbsf_pkg::PROD_W;
    localparam int AW    = sbsf_pkg::AREA_W;
    localparam int ACC_W = PW + MW;

    function automatic logic [SPW-1:0] span_of(input sbsf_pkg::coord_t lo,
                                                input sbsf_pkg::coord_t hi);
        logic [sbsf_pkg::COORD_BITS:0] d;
        d = {hi[sbsf_pkg::COORD_BITS-1], hi} - {lo[sbsf_pkg::COORD_BITS-1], lo};
        return (hi > lo) ? d[SPW-1:0] : '0;
    endfunction

    logic             busy_reg;
    logic             done_reg;
    logic [2:0]       step_reg;
    logic [SPW-1:0]   ex_reg;
    logic [SPW-1:0]   ey_reg;
    logic [SPW-1:0]   ez_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PW-1:0]    prod_reg;
    logic [AW-1:0]    s2_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [sbsf_pkg::COST_W-1:0] cost_reg;
    logic [MW-1:0]    mul_a;
    logic [MW-1:0]    mul_b;

    always_comb
    begin
        unique case (step_reg)
            3'd0:
            begin
                mul_a = MW'(ex_reg);
                mul_b = MW'(ey_reg);
            end
            3'd1:
            begin
                mul_a = MW'(ey_reg);
                mul_b = MW'(ez_reg);
            end
            3'd2:
            begin
                mul_a = MW'(ez_reg);
                mul_b = MW'(ex_reg);
            end
            3'd4:
            begin
                mul_a = s2_reg[MW-1:0];
                mul_b = MW'(cnt_reg);
            end
            3'd5:
            begin
                mul_a = MW'(s2_reg[AW-1:MW]);
                mul_b = MW'(cnt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ex_reg  <= span_of(box.lo_x, box.hi_x);
            ey_reg  <= span_of(box.lo_y, box.hi_y);
            ez_reg  <= span_of(box.lo_z, box.hi_z);
            cnt_reg <= count;
            s2_reg  <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= mul_a * mul_b;
            unique case (step_reg)
                3'd1, 3'd2, 3'd3:
                begin
                    s2_reg <= s2_reg + (AW'(prod_reg) << 1);
                end
                3'd5:
                begin
                    acc_reg <= ACC_W'(prod_reg);
                end
                3'd6:
                begin
                    acc_reg <= acc_reg + (ACC_W'(prod_reg) << MW);
                end
                3'd7:
                begin
                    cost_reg <= (acc_reg > ACC_W'(sbsf_pkg::COST_MAX)) ?
                                sbsf_pkg::COST_MAX : acc_reg[sbsf_pkg::COST_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign done = done_reg;
    assign cost = cost_reg;

endmodule

`default_nettype wire

FILE: sv/sah_binned_split_finder_core.sv
// Binned SAH split finder top level: load sequencer, bins, sweeps and result register.
// Depends on sbsf_pkg, sbsf_prim_store, sbsf_bin_div and sbsf_cost.
//
// Primitives arrive on the item channel (item_valid/item_ready), one word per cycle
// while the block is loading. A word with last_item set closes the set; item_ready
// then drops until the result word has been taken on the result channel
// (result_valid/result_ready). After the last word the block picks the axis, then
// bins each stored primitive in turn (store read, divider start, the four quotient
// bits and a done step), with the divider ending early when the bin index clamps.
// Each of the fifteen bin boundaries then passes a take state and a cost state in
// each of the two sweeps, plus a run of the eight-step cost unit where a cost is
// needed, and a finish state forms the result word. A flat set goes from the axis
// choice straight to the result word. The result word holds until result_ready is
// seen; a stalled receiver simply keeps the block waiting. Reset empties the set
// and leaves the block ready for the first word.
`default_nettype none

module sah_binned_split_finder_core #(
    parameter int MAX_PRIMS = sbsf_pkg::MAX_PRIMS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    output logic                                      item_ready,
    input  wire logic signed [sbsf_pkg::COORD_BITS-1:0] box_min_x,
    input  wire logic signed [sbsf_pkg::COORD_BITS-1:0] box_min_y,
    input  wire logic signed [sbsf_pkg::COORD_BITS-1:0] box_min_z,
    input  wire logic signed [sbsf_pkg::COORD_BITS-1:0] box_max_x,
    input  wire logic signed [sbsf_pkg::COORD_BITS-1:0] box_max_y,
    input  wire logic signed [sbsf_pkg::COORD_BITS-1:0] box_max_z,
    input  wire logic signed [sbsf_pkg::COORD_BITS-1:0] center_x,
    input  wire logic signed [sbsf_pkg::COORD_BITS-1:0] center_y,
    input  wire logic signed [sbsf_pkg::COORD_BITS-1:0] center_z,
    input  wire logic                                 last_item,
    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output logic [1:0]                                cut_axis,
    output logic signed [sbsf_pkg::COORD_BITS-1:0]    split_position,
    output logic [sbsf_pkg::BIN_W-1:0]                split_bin,
    output logic [sbsf_pkg::COST_W-1:0]               split_cost,
    output logic [1:0]                                status
);

    localparam int CB    = sbsf_pkg::COORD_BITS;
    localparam int NB    = sbsf_pkg::NUM_BINS;
    localparam int BW    = sbsf_pkg::BIN_W;
    localparam int CW    = sbsf_pkg::COST_W;
    localparam int CNT_W = $clog2(MAX_PRIMS + 1);
    localparam int AW    = $clog2(MAX_PRIMS);

    typedef enum logic [12:0] {
        S_LOAD     = 13'h0001,
        S_EVAL     = 13'h0002,
        S_BIN_ADDR = 13'h0004,
        S_BIN_DATA = 13'h0008,
        S_BIN_DIV  = 13'h0010,
        S_RSW_TAKE = 13'h0020,
        S_RSW_COST = 13'h0040,
        S_RSW_WAIT = 13'h0080,
        S_LSW_TAKE = 13'h0100,
        S_LSW_COST = 13'h0200,
        S_LSW_WAIT = 13'h0400,
        S_FINISH   = 13'h0800,
        S_OUT      = 13'h1000
    } state_t;

    function automatic sbsf_pkg::box_t merge_box(input sbsf_pkg::box_t u,
                                                  input sbsf_pkg::box_t s,
                                                  input logic valid);
        sbsf_pkg::box_t r;
        r.lo_x = (!valid || s.lo_x < u.lo_x) ? s.lo_x : u.lo_x;
        r.lo_y = (!valid || s.lo_y < u.lo_y) ? s.lo_y : u.lo_y;
        r.lo_z = (!valid || s.lo_z < u.lo_z) ? s.lo_z : u.lo_z;
        r.hi_x = (!valid || s.hi_x > u.hi_x) ? s.hi_x : u.hi_x;
        r.hi_y = (!valid || s.hi_y > u.hi_y) ? s.hi_y : u.hi_y;
        r.hi_z = (!valid || s.hi_z > u.hi_z) ? s.hi_z : u.hi_z;
        return r;
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]       total_reg;
    sbsf_pkg::coord_t       cmin_reg [3];
    sbsf_pkg::coord_t       cmax_reg [3];
    logic [1:0]             axis_reg;
    sbsf_pkg::coord_t       bmin_reg;
    logic [CB-1:0]          extent_reg;
    logic [CNT_W-1:0]       idx_reg;
    sbsf_pkg::box_t         bin_box_reg [NB];
    logic [CNT_W-1:0]       bin_fill_reg [NB];
    logic [BW-1:0]          sweep_b_reg;
    sbsf_pkg::box_t         ubox_reg;
    logic                   uvalid_reg;
    logic [CNT_W-1:0]       ucnt_reg;
    logic [CW-1:0]          rcost_reg [NB-1];
    logic [CNT_W-1:0]       rfill_reg [NB-1];
    logic                   found_reg;
    logic [CW-1:0]          win_cost_reg;
    logic [BW-1:0]          win_bin_reg;
    logic                   out_valid_reg;
    logic [1:0]             axis_out_reg;
    logic [CB-1:0]          pos_out_reg;
    logic [BW-1:0]          bin_out_reg;
    logic [CW-1:0]          cost_out_reg;
    logic [1:0]             status_out_reg;

    sbsf_pkg::coord_t       c_in [3];
    logic                   item_fire;
    logic                   store_ok;
    sbsf_pkg::prim_t        wr_prim;
    sbsf_pkg::prim_t        rd_prim;
    logic                   rd_en;
    logic signed [CB:0]     ext [3];
    logic [1:0]             eval_axis;
    sbsf_pkg::coord_t       eval_min;
    logic signed [CB:0]     eval_ext;
    logic                   flat;
    sbsf_pkg::coord_t       rd_center;
    logic [CB:0]            center_diff;
    logic                   div_start;
    logic                   div_done;
    logic [BW-1:0]          div_q;
    logic                   last_prim;
    logic [BW-1:0]          bin_addr;
    sbsf_pkg::box_t         sel_box;
    logic [CNT_W-1:0]       sel_fill;
    logic [BW-1:0]          rsw_idx;
    logic                   cost_start;
    logic                   cost_done;
    logic [CW-1:0]          cost_val;
    logic                   lsw_need;
    logic                   rsw_adv;
    logic                   lsw_adv;
    logic [CW:0]            pair_sum;
    logic [CW-1:0]          pair_cost;
    logic                   better;
    logic [CB+BW:0]         scaled;
    logic [CB-1:0]          fin_pos;
    logic                   clear_set;

    always_comb
    begin
        c_in[0]   = center_x;
        c_in[1]   = center_y;
        c_in[2]   = center_z;
        item_fire = item_valid && item_ready;
        store_ok  = total_reg < CNT_W'(MAX_PRIMS);
        wr_prim   = '{box: '{lo_x: box_min_x, lo_y: box_min_y, lo_z: box_min_z,
                             hi_x: box_max_x, hi_y: box_max_y, hi_z: box_max_z},
                      cx: center_x, cy: center_y, cz: center_z};

        for (int k = 0; k < 3; k++)
        begin
            ext[k] = {cmax_reg[k][CB-1], cmax_reg[k]} - {cmin_reg[k][CB-1], cmin_reg[k]};
        end
        if (ext[0] > ext[1] && ext[0] > ext[2])
        begin
            eval_axis = sbsf_pkg::AXIS_X;
            eval_min  = cmin_reg[0];
            eval_ext  = ext[0];
        end
        else if (ext[1] > ext[2])
        begin
            eval_axis = sbsf_pkg::AXIS_Y;
            eval_min  = cmin_reg[1];
            eval_ext  = ext[1];
        end
        else
        begin
            eval_axis = sbsf_pkg::AXIS_Z;
            eval_min  = cmin_reg[2];
            eval_ext  = ext[2];
        end
        flat = eval_ext <= 0;

        unique case (axis_reg)
            sbsf_pkg::AXIS_X: rd_center = rd_prim.cx;
            sbsf_pkg::AXIS_Y: rd_center = rd_prim.cy;
            default:          rd_center = rd_prim.cz;
        endcase
        center_diff = {rd_center[CB-1], rd_center} - {bmin_reg[CB-1], bmin_reg};
        last_prim   = CNT_W'(idx_reg + 1'b1) == total_reg;

        bin_addr = (state_reg == S_BIN_DIV) ? div_q : sweep_b_reg;
        sel_box  = bin_box_reg[bin_addr];
        sel_fill = bin_fill_reg[bin_addr];
        rsw_idx  = sweep_b_reg - 1'b1;

        lsw_need  = ucnt_reg != '0 && rfill_reg[sweep_b_reg] != '0;
        rsw_adv   = (state_reg == S_RSW_COST && !uvalid_reg) ||
                    (state_reg == S_RSW_WAIT && cost_done);
        lsw_adv   = (state_reg == S_LSW_COST && !lsw_need) ||
                    (state_reg == S_LSW_WAIT && cost_done);
        pair_sum  = {1'b0, cost_val} + {1'b0, rcost_reg[sweep_b_reg]};
        pair_cost = (pair_sum > (CW + 1)'(sbsf_pkg::COST_MAX)) ?
                    sbsf_pkg::COST_MAX : pair_sum[CW-1:0];
        better    = !found_reg || pair_cost < win_cost_reg;

        scaled  = (CB + BW + 1)'(extent_reg) * (CB + BW + 1)'({1'b0, win_bin_reg} + 1'b1);
        fin_pos = found_reg ? bmin_reg + scaled[CB+BW-1:BW] : bmin_reg + (extent_reg >> 1);

        clear_set = (state_reg == S_EVAL && flat) || state_reg == S_FINISH;
    end

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        div_start  = 1'b0;
        cost_start = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (item_fire && last_item)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = flat ? S_OUT : S_BIN_ADDR;
            end
            S_BIN_ADDR:
            begin
                rd_en      = 1'b1;
                state_next = S_BIN_DATA;
            end
            S_BIN_DATA:
            begin
                div_start  = 1'b1;
                state_next = S_BIN_DIV;
            end
            S_BIN_DIV:
            begin
                if (div_done)
                begin
                    state_next = last_prim ? S_RSW_TAKE : S_BIN_ADDR;
                end
            end
            S_RSW_TAKE:
            begin
                state_next = S_RSW_COST;
            end
            S_RSW_COST, S_RSW_WAIT:
            begin
                if (state_reg == S_RSW_COST && uvalid_reg)
                begin
                    cost_start = 1'b1;
                    state_next = S_RSW_WAIT;
                end
                else if (rsw_adv)
                begin
                    state_next = (sweep_b_reg == BW'(1)) ? S_LSW_TAKE : S_RSW_TAKE;
                end
            end
            S_LSW_TAKE:
            begin
                state_next = S_LSW_COST;
            end
            S_LSW_COST, S_LSW_WAIT:
            begin
                if (state_reg == S_LSW_COST && lsw_need)
                begin
                    cost_start = 1'b1;
                    state_next = S_LSW_WAIT;
                end
                else if (lsw_adv)
                begin
                    state_next = (sweep_b_reg == BW'(NB - 2)) ? S_FINISH : S_LSW_TAKE;
                end
            end
            S_FINISH:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (result_ready)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            total_reg     <= '0;
            idx_reg       <= '0;
            sweep_b_reg   <= '0;
            uvalid_reg    <= 1'b0;
            ucnt_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                cmin_reg[k] <= sbsf_pkg::COORD_HI;
                cmax_reg[k] <= sbsf_pkg::COORD_LO;
            end
            for (int k = 0; k < NB; k++)
            begin
                bin_fill_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (item_fire && store_ok)
                    begin
                        total_reg <= total_reg + 1'b1;
                        for (int k = 0; k < 3; k++)
                        begin
                            if (c_in[k] < cmin_reg[k])
                            begin
                                cmin_reg[k] <= c_in[k];
                            end
                            if (c_in[k] > cmax_reg[k])
                            begin
                                cmax_reg[k] <= c_in[k];
                            end
                        end
                    end
                end
                S_EVAL:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    if (flat)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                S_BIN_DIV:
                begin
                    if (div_done)
                    begin
                        bin_fill_reg[bin_addr] <= sel_fill + 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        if (last_prim)
                        begin
                            sweep_b_reg <= BW'(NB - 1);
                            uvalid_reg  <= 1'b0;
                            ucnt_reg    <= '0;
                        end
                    end
                end
                S_RSW_TAKE, S_LSW_TAKE:
                begin
                    if (sel_fill != '0)
                    begin
                        uvalid_reg <= 1'b1;
                        ucnt_reg   <= ucnt_reg + sel_fill;
                    end
                end
                S_RSW_COST, S_RSW_WAIT:
                begin
                    if (rsw_adv)
                    begin
                        if (sweep_b_reg == BW'(1))
                        begin
                            sweep_b_reg <= '0;
                            uvalid_reg  <= 1'b0;
                            ucnt_reg    <= '0;
                        end
                        else
                        begin
                            sweep_b_reg <= sweep_b_reg - 1'b1;
                        end
                    end
                end
                S_LSW_COST, S_LSW_WAIT:
                begin
                    if (state_reg == S_LSW_WAIT && cost_done && better)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (lsw_adv)
                    begin
                        sweep_b_reg <= sweep_b_reg + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (result_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (clear_set)
            begin
                total_reg <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    cmin_reg[k] <= sbsf_pkg::COORD_HI;
                    cmax_reg[k] <= sbsf_pkg::COORD_LO;
                end
                for (int k = 0; k < NB; k++)
                begin
                    bin_fill_reg[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_EVAL:
            begin
                axis_reg   <= eval_axis;
                bmin_reg   <= eval_min;
                extent_reg <= eval_ext[CB-1:0];
                if (flat)
                begin
                    axis_out_reg   <= eval_axis;
                    pos_out_reg    <= eval_min;
                    bin_out_reg    <= '0;
                    cost_out_reg   <= sbsf_pkg::COST_MAX;
                    status_out_reg <= sbsf_pkg::ST_FLAT;
                end
            end
            S_BIN_DIV:
            begin
                if (div_done)
                begin
                    bin_box_reg[bin_addr] <= merge_box(sel_box, rd_prim.box, sel_fill != '0);
                end
            end
            S_RSW_TAKE, S_LSW_TAKE:
            begin
                if (sel_fill != '0)
                begin
                    ubox_reg <= merge_box(ubox_reg, sel_box, uvalid_reg);
                end
            end
            S_RSW_COST:
            begin
                rfill_reg[rsw_idx] <= ucnt_reg;
                if (!uvalid_reg)
                begin
                    rcost_reg[rsw_idx] <= '0;
                end
            end
            S_RSW_WAIT:
            begin
                if (cost_done)
                begin
                    rcost_reg[rsw_idx] <= cost_val;
                end
            end
            S_LSW_WAIT:
            begin
                if (cost_done && better)
                begin
                    win_cost_reg <= pair_cost;
                    win_bin_reg  <= sweep_b_reg;
                end
            end
            S_FINISH:
            begin
                axis_out_reg   <= axis_reg;
                pos_out_reg    <= fin_pos;
                bin_out_reg    <= found_reg ? win_bin_reg : '0;
                cost_out_reg   <= found_reg ? win_cost_reg : sbsf_pkg::COST_MAX;
                status_out_reg <= found_reg ? sbsf_pkg::ST_SPLIT : sbsf_pkg::ST_NONE;
            end
            default:
            begin
            end
        endcase
    end

    sbsf_prim_store #(
        .DEPTH(MAX_PRIMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (item_fire && store_ok),
        .wr_addr (total_reg[AW-1:0]),
        .wr_data (wr_prim),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_prim)
    );

    sbsf_bin_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (center_diff[CB-1:0]),
        .divisor  (extent_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    sbsf_cost #(
        .CNT_W(CNT_W)
    ) u_cost (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cost_start),
        .box   (ubox_reg),
        .count (ucnt_reg),
        .done  (cost_done),
        .cost  (cost_val)
    );

    assign item_ready     = state_reg == S_LOAD;
    assign result_valid   = out_valid_reg;
    assign cut_axis       = axis_out_reg;
    assign split_position = pos_out_reg;
    assign split_bin      = bin_out_reg;
    assign split_cost     = cost_out_reg;
    assign status         = status_out_reg;

endmodule

`default_nettype wire

FILE: sv/sbsf_checker.sv
// Port-level checks of the split finder and the bind that attaches them.
// Depends on sbsf_pkg and on the ports of sah_binned_split_finder_core.
`default_nettype none

module sbsf_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               item_valid,
    input wire logic                               item_ready,
    input wire logic                               last_item,
    input wire logic                               result_valid,
    input wire logic                               result_ready,
    input wire logic [sbsf_pkg::BIN_W-1:0]         split_bin,
    input wire logic [sbsf_pkg::COST_W-1:0]        split_cost,
    input wire logic [1:0]                         status
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("item channel ready while a result word is pending");

    a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !last_item |=> item_ready)
        else $error("block stalled after a word that did not close the set");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready |=> item_ready && !result_valid)
        else $error("block did not return to loading after the result word");

    a_no_split_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != sbsf_pkg::ST_SPLIT |->
            split_cost == sbsf_pkg::COST_MAX && split_bin == '0)
        else $error("result without a split carries a bin or a finite cost");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(split_cost) && $stable(status))
        else $error("stalled result word changed");

endmodule

bind sah_binned_split_finder_core sbsf_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .last_item    (last_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .split_bin    (split_bin),
    .split_cost   (split_cost),
    .status       (status)
);

`default_nettype wire
